### rtl/mpct_pkg.sv
`default_nettype none
package mpct_pkg;

  localparam int unsigned COORD_W = 7;
  localparam int unsigned CELL_W  = 14;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned BTN_W   = 3;
  localparam int unsigned CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_COLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_ROWS = 2'd1;

  // packet byte positions
  localparam logic [1:0] BYTE_BUTTONS = 2'd0;
  localparam logic [1:0] BYTE_DX      = 2'd1;

  localparam logic [COORD_W-1:0] COLS_RESET = 7'd80;
  localparam logic [COORD_W-1:0] ROWS_RESET = 7'd25;
  localparam logic [COORD_W-1:0] X_RESET    = 7'd40;
  localparam logic [COORD_W-1:0] Y_RESET    = 7'd12;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [CELL_W-1:0]  cell_t;

endpackage
`default_nettype wire

### rtl/mouse_packet_cursor_tracker_unit.sv
`default_nettype none
// Mouse packet cursor tracker. Raw bytes of a three-byte mouse packet
// (buttons, signed dx, signed dy) enter on the in_ channel, one byte per
// transaction, and one transaction is accepted in every cycle when the result
// side keeps up. The first two bytes of a packet produce nothing; the third
// produces one result transaction with the clamped cursor position, the cell
// offsets (row * screen_cols + col) of the old and new cursor cells with their
// invert flags, and the press edges of the left, right and middle buttons.
// A byte passes one input register, then one pass of adders, a clamp and a
// 7x7 multiply-add into the output register. A waiting result holds the
// output register and stalls the input register only when a new result is
// due. The user writes screen_cols and screen_rows on the cfg_ port only
// while no transaction is in flight (unenforced); a size of zero clamps as one.
module mouse_packet_cursor_tracker_unit
  import mpct_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // configuration writes
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COORD_W-1:0]   cfg_data,
  // raw mouse bytes
  input  wire logic                 in_valid,
  output      logic                 in_ready,
  input  wire logic [BYTE_W-1:0]    in_data_byte,
  // packet results
  output      logic                 out_valid,
  input  wire logic                 out_ready,
  output      logic [COORD_W-1:0]   out_cursor_col,
  output      logic [COORD_W-1:0]   out_cursor_row,
  output      logic                 out_invert_old,
  output      logic [CELL_W-1:0]    out_old_cell,
  output      logic                 out_invert_new,
  output      logic [CELL_W-1:0]    out_new_cell,
  output      logic                 out_left_pressed,
  output      logic                 out_right_pressed,
  output      logic                 out_middle_pressed
);

  // configuration registers
  coord_t cols_r;
  coord_t rows_r;

  // input register
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;

  // packet state
  logic [1:0]        byte_idx_r;
  logic [BYTE_W-1:0] btn_byte_r;   // no reset: always written before use
  logic [BYTE_W-1:0] dx_byte_r;
  coord_t            cur_x_r;
  coord_t            cur_y_r;
  logic              highlight_r;
  logic [BTN_W-1:0]  prev_btn_r;

  // output register
  logic             out_valid_r;
  coord_t           col_r, row_r;
  logic             inv_old_r, inv_new_r;
  cell_t            old_cell_r, new_cell_r;
  logic [BTN_W-1:0] press_r;

  logic s1_adv;
  logic last_byte;

  // next-value logic
  logic [BTN_W-1:0]   buttons;
  logic signed [9:0]  pos_x, pos_y;
  coord_t             top_x, top_y;
  coord_t             nx, ny;
  logic [CELL_W-1:0]  old_cell_nxt, new_cell_nxt;

  // a third byte needs the output register free; the others always move on
  assign last_byte = (byte_idx_r != BYTE_BUTTONS) && (byte_idx_r != BYTE_DX);
  assign s1_adv    = s1_valid_r && (!last_byte || !out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_adv;

  always_comb begin
    buttons = btn_byte_r[BTN_W-1:0];
    // a size of zero clamps to coordinate zero
    top_x = (cols_r == '0) ? '0 : cols_r - 7'd1;
    top_y = (rows_r == '0) ? '0 : rows_r - 7'd1;
    pos_x = $signed({3'b000, cur_x_r}) + 10'($signed(dx_byte_r));
    pos_y = $signed({3'b000, cur_y_r}) - 10'($signed(s1_byte_r));
    if (pos_x < 0) begin
      nx = '0;
    end else if (pos_x > $signed({3'b000, top_x})) begin
      nx = top_x;
    end else begin
      nx = pos_x[COORD_W-1:0];
    end
    if (pos_y < 0) begin
      ny = '0;
    end else if (pos_y > $signed({3'b000, top_y})) begin
      ny = top_y;
    end else begin
      ny = pos_y[COORD_W-1:0];
    end
    old_cell_nxt = CELL_W'(cur_y_r * cols_r) + CELL_W'(cur_x_r);
    new_cell_nxt = CELL_W'(ny * cols_r) + CELL_W'(nx);
  end

  // configuration port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= COLS_RESET;
      rows_r <= ROWS_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_SCREEN_COLS: cols_r <= cfg_data;
        CFG_SCREEN_ROWS: rows_r <= cfg_data;
        default: ;  // unknown index ignored
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_data_byte;
    end
  end

  // packet assembly and cursor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_idx_r  <= BYTE_BUTTONS;
      cur_x_r     <= X_RESET;
      cur_y_r     <= Y_RESET;
      highlight_r <= 1'b0;
      prev_btn_r  <= '0;
    end else if (s1_adv) begin
      if (last_byte) begin
        byte_idx_r  <= BYTE_BUTTONS;
        cur_x_r     <= nx;
        cur_y_r     <= ny;
        highlight_r <= (buttons != '0);
        prev_btn_r  <= buttons;
      end else begin
        byte_idx_r <= byte_idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && byte_idx_r == BYTE_BUTTONS) begin
      btn_byte_r <= s1_byte_r;
    end
    if (s1_adv && byte_idx_r == BYTE_DX) begin
      dx_byte_r <= s1_byte_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && last_byte) begin
      col_r      <= nx;
      row_r      <= ny;
      inv_old_r  <= !highlight_r;
      old_cell_r <= old_cell_nxt;
      inv_new_r  <= (buttons == '0);
      new_cell_r <= new_cell_nxt;
      press_r    <= buttons & ~prev_btn_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_cursor_col     = col_r;
  assign out_cursor_row     = row_r;
  assign out_invert_old     = inv_old_r;
  assign out_old_cell       = old_cell_r;
  assign out_invert_new     = inv_new_r;
  assign out_new_cell       = new_cell_r;
  assign out_left_pressed   = press_r[0];
  assign out_right_pressed  = press_r[1];
  assign out_middle_pressed = press_r[2];

endmodule
`default_nettype wire

### rtl/mpct_checker.sv
`default_nettype none
module mpct_checker
  import mpct_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [COORD_W-1:0]   out_cursor_col,
  input wire logic [COORD_W-1:0]   out_cursor_row,
  input wire logic                 out_invert_new,
  input wire logic [CELL_W-1:0]    out_new_cell,
  input wire logic                 out_left_pressed,
  input wire logic                 out_right_pressed,
  input wire logic                 out_middle_pressed
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_new_cell)
      && $stable(out_cursor_col) && $stable(out_cursor_row))
    else $error("stalled result changed");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a press edge means a button is held, so the new cell is not inverted
  a_press_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_left_pressed || out_right_pressed || out_middle_pressed)
      |-> !out_invert_new)
    else $error("press edge with no button held");

  // the origin cell has offset zero
  a_origin_cell: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cursor_col == '0 && out_cursor_row == '0 |-> out_new_cell == '0)
    else $error("origin cell offset not zero");

  // with the output register empty nothing blocks the input
  a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with no result waiting");

endmodule

bind mouse_packet_cursor_tracker_unit mpct_checker u_mpct_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_cursor_col     (out_cursor_col),
  .out_cursor_row     (out_cursor_row),
  .out_invert_new     (out_invert_new),
  .out_new_cell       (out_new_cell),
  .out_left_pressed   (out_left_pressed),
  .out_right_pressed  (out_right_pressed),
  .out_middle_pressed (out_middle_pressed)
);
`default_nettype wire
